// ----- src/fgm_pkg.sv -----
package fgm_pkg;

  localparam int unsigned IndexWidthDef = 63;
  localparam int unsigned ModWidth      = 31;
  localparam logic [ModWidth-1:0] ModReset = 31'd1000000007;

  typedef struct packed {
    logic load;
    logic gcd_step;
    logic shl_step;
    logic fib_init;
    logic align_step;
    logic sq_start;
    logic sq_step;
    logic round_end;
    logic out_load;
  } fgm_cmd_t;

  typedef struct packed {
    logic gcd_done;
    logic k_zero;
    logic exp_msb;
    logic mod_zero;
  } fgm_sts_t;

endpackage

// ----- src/fgm_in_if.sv -----
interface fgm_in_if #(
  parameter int unsigned IW = 63
);
  logic          valid;
  logic          ready;
  logic [IW-1:0] first_index;
  logic [IW-1:0] second_index;

  modport source (output valid, output first_index, output second_index, input ready);
  modport sink (input valid, input first_index, input second_index, output ready);
endinterface

// ----- src/fgm_out_if.sv -----
interface fgm_out_if;
  import fgm_pkg::*;
  logic                valid;
  logic                ready;
  logic [ModWidth-1:0] fib_value;

  modport source (output valid, output fib_value, input ready);
  modport sink (input valid, input fib_value, output ready);
endinterface

// ----- src/fgm_ctrl.sv -----
module fgm_ctrl #(
  parameter int unsigned INDEX_WIDTH = 63
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  fgm_pkg::fgm_sts_t sts_i,
  output fgm_pkg::fgm_cmd_t cmd_o
);
  import fgm_pkg::*;

  localparam int unsigned CW = $clog2(INDEX_WIDTH + 1);
  localparam int unsigned BW = $clog2(ModWidth);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GCD   = 3'd1;
  localparam logic [2:0] S_SHL   = 3'd2;
  localparam logic [2:0] S_ALIGN = 3'd3;
  localparam logic [2:0] S_SQ    = 3'd4;
  localparam logic [2:0] S_BASE  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] rnd_q, rnd_d;
  logic [BW-1:0] bit_q, bit_d;
  logic          ovalid_q, ovalid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d  = state_q;
    rnd_d    = rnd_q;
    bit_d    = bit_q;
    ovalid_d = ovalid_q && !out_ready_i;
    cmd_o    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_GCD;
        end
      end
      S_GCD: begin
        cmd_o.gcd_step = 1'b1;
        if (sts_i.gcd_done) begin
          state_d = S_SHL;
        end
      end
      S_SHL: begin
        if (sts_i.k_zero) begin
          cmd_o.fib_init = 1'b1;
          rnd_d          = CW'(INDEX_WIDTH);
          state_d        = S_ALIGN;
        end else begin
          cmd_o.shl_step = 1'b1;
        end
      end
      S_ALIGN: begin
        // Leading zero bits of the exponent leave the identity unchanged.
        if (sts_i.mod_zero || rnd_q == '0) begin
          state_d = S_DONE;
        end else if (sts_i.exp_msb) begin
          cmd_o.sq_start = 1'b1;
          bit_d          = BW'(ModWidth - 1);
          state_d        = S_SQ;
        end else begin
          cmd_o.align_step = 1'b1;
          rnd_d            = rnd_q - 1'b1;
        end
      end
      S_SQ: begin
        cmd_o.sq_step = 1'b1;
        if (bit_q == '0) begin
          state_d = S_BASE;
        end else begin
          bit_d = bit_q - 1'b1;
        end
      end
      S_BASE: begin
        cmd_o.round_end = 1'b1;
        rnd_d           = rnd_q - 1'b1;
        if (rnd_q == CW'(1)) begin
          state_d = S_DONE;
        end else begin
          cmd_o.sq_start = 1'b1;
          bit_d          = BW'(ModWidth - 1);
          state_d        = S_SQ;
        end
      end
      S_DONE: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          ovalid_d       = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rnd_q    <= '0;
      bit_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rnd_q    <= rnd_d;
      bit_q    <= bit_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

// ----- src/fgm_dp.sv -----
module fgm_dp #(
  parameter int unsigned INDEX_WIDTH = 63
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fgm_pkg::ModWidth-1:0] cfg_data_i,
  input  logic [INDEX_WIDTH-1:0]       first_index_i,
  input  logic [INDEX_WIDTH-1:0]       second_index_i,
  input  fgm_pkg::fgm_cmd_t            cmd_i,
  output fgm_pkg::fgm_sts_t            sts_o,
  output logic [fgm_pkg::ModWidth-1:0] fib_value_o
);
  import fgm_pkg::*;

  localparam int unsigned KW = $clog2(INDEX_WIDTH + 1);
  localparam int unsigned MW = ModWidth;

  logic [MW-1:0]          mod_q;
  logic [MW:0]            m2_q;
  logic [MW+1:0]          m3_q;
  logic [INDEX_WIDTH-1:0] a_q, b_q, e_q;
  logic [KW-1:0]          k_q;
  // Accumulated power [[p,q],[q,r]], shifting copies and partial products.
  logic [MW-1:0]          yp_q, yq_q, yr_q;
  logic [MW-1:0]          sp_q, sq_q, sr_q;
  logic [MW-1:0]          tp_q, tq_q, tr_q;
  logic [MW-1:0]          res_q;

  logic [MW-1:0]          tp_d, tq_d, tr_d;
  logic [MW-1:0]          np, nq, nr;
  logic [MW:0]            bsum;
  logic                   one_bit;

  function automatic logic [MW-1:0] lane_step(
    input logic [MW-1:0] t, input logic b1, input logic [MW-1:0] y1,
    input logic b2, input logic [MW-1:0] y2, input logic [MW-1:0] m,
    input logic [MW:0] m2, input logic [MW+1:0] m3);
    logic [MW+1:0] s;
    logic [MW+1:0] r;
    s = {1'b0, t, 1'b0} + {2'b00, y1 & {MW{b1}}} + {2'b00, y2 & {MW{b2}}};
    if (s >= m3) begin
      r = s - m3;
    end else if (s >= {1'b0, m2}) begin
      r = s - {1'b0, m2};
    end else if (s >= {2'b00, m}) begin
      r = s - {2'b00, m};
    end else begin
      r = s;
    end
    return r[MW-1:0];
  endfunction

  assign sts_o.gcd_done = (a_q == '0) || (b_q == '0);
  assign sts_o.k_zero   = (k_q == '0);
  assign sts_o.exp_msb  = e_q[INDEX_WIDTH-1];
  assign sts_o.mod_zero = (mod_q == '0);
  assign fib_value_o    = res_q;
  assign one_bit        = (mod_q != MW'(1));

  always_comb begin
    tp_d = lane_step(tp_q, sp_q[MW-1], yp_q, sq_q[MW-1], yq_q, mod_q, m2_q, m3_q);
    tq_d = lane_step(tq_q, sp_q[MW-1], yq_q, sq_q[MW-1], yr_q, mod_q, m2_q, m3_q);
    tr_d = lane_step(tr_q, sq_q[MW-1], yq_q, sr_q[MW-1], yr_q, mod_q, m2_q, m3_q);
    bsum = {1'b0, tp_q} + {1'b0, tq_q};
    if (e_q[INDEX_WIDTH-1]) begin
      // Multiply by [[1,1],[1,0]]: the new bottom-right is the old off-diagonal.
      np = (bsum >= {1'b0, mod_q}) ? MW'(bsum - {1'b0, mod_q}) : bsum[MW-1:0];
      nq = tp_q;
      nr = tq_q;
    end else begin
      np = tp_q;
      nq = tq_q;
      nr = tr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= ModReset;
    end else if (cfg_we_i) begin
      mod_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q <= first_index_i;
      b_q <= second_index_i;
      k_q <= '0;
    end
    if (cmd_i.gcd_step) begin
      if (sts_o.gcd_done) begin
        e_q <= a_q | b_q;
      end else if (!a_q[0] && !b_q[0]) begin
        a_q <= a_q >> 1;
        b_q <= b_q >> 1;
        k_q <= k_q + 1'b1;
      end else if (!a_q[0]) begin
        a_q <= a_q >> 1;
      end else if (!b_q[0]) begin
        b_q <= b_q >> 1;
      end else if (a_q >= b_q) begin
        a_q <= (a_q - b_q) >> 1;
      end else begin
        b_q <= (b_q - a_q) >> 1;
      end
    end
    if (cmd_i.shl_step) begin
      e_q <= e_q << 1;
      k_q <= k_q - 1'b1;
    end
    if (cmd_i.fib_init) begin
      m2_q <= {mod_q, 1'b0};
      m3_q <= {1'b0, mod_q, 1'b0} + {2'b00, mod_q};
      yp_q <= MW'(one_bit);
      yq_q <= '0;
      yr_q <= MW'(one_bit);
    end
    if (cmd_i.align_step) begin
      e_q <= e_q << 1;
    end
    if (cmd_i.sq_step) begin
      tp_q <= tp_d;
      tq_q <= tq_d;
      tr_q <= tr_d;
      sp_q <= sp_q << 1;
      sq_q <= sq_q << 1;
      sr_q <= sr_q << 1;
    end
    if (cmd_i.round_end) begin
      yp_q <= np;
      yq_q <= nq;
      yr_q <= nr;
      e_q  <= e_q << 1;
    end
    if (cmd_i.sq_start) begin
      tp_q <= '0;
      tq_q <= '0;
      tr_q <= '0;
      if (cmd_i.round_end) begin
        sp_q <= np;
        sq_q <= nq;
        sr_q <= nr;
      end else begin
        sp_q <= yp_q;
        sq_q <= yq_q;
        sr_q <= yr_q;
      end
    end
    if (cmd_i.out_load) begin
      res_q <= yq_q;
    end
  end

endmodule

// ----- src/fibonacci_of_gcd_mod_unit.sv -----
// Channel  Dir  Fields                       Transaction
// in_i     in   first_index, second_index    valid & ready at clk_i rise
// out_o    out  fib_value                    valid & ready at clk_i rise
//
// One item at a time. The binary GCD runs first, then the restoring shift of common
// twos, then one align step per leading zero of the gcd and, per remaining exponent
// bit, a 31-step bit-serial modular square on three lanes plus one base-multiply
// step. Reset sets the modulus to 1000000007; a stalled result holds in the
// result register.
module fibonacci_of_gcd_mod_unit #(
  parameter int unsigned INDEX_WIDTH = fgm_pkg::IndexWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fgm_pkg::ModWidth-1:0] cfg_data_i,
  fgm_in_if.sink                       in_i,
  fgm_out_if.source                    out_o
);
  import fgm_pkg::*;

  fgm_cmd_t cmd;
  fgm_sts_t sts;

  fgm_ctrl #(
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fgm_dp #(
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .first_index_i (in_i.first_index),
    .second_index_i(in_i.second_index),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .fib_value_o   (out_o.fib_value)
  );

endmodule

// ----- test/fibonacci_of_gcd_mod_unit_tb.sv -----
module fibonacci_of_gcd_mod_unit_tb;
  import fgm_pkg::*;

  localparam int unsigned IW = 63;
  localparam longint unsigned CYCLE_LIMIT = 64'd12_000_000;
  localparam logic [IW-1:0] IDX_MAX = {IW{1'b1}};

  class fib_gcd_scoreboard;
    logic [ModWidth-1:0] modulus;
    logic [ModWidth-1:0] pending_values[$];
    int unsigned fails;

    function new();
      modulus = ModReset;
      fails = 0;
    endfunction

    function longint unsigned euclid_gcd(longint unsigned a, longint unsigned b);
      longint unsigned r;
      while (b != 0) begin
        r = a % b;
        a = b;
        b = r;
      end
      return a;
    endfunction

    // Raises [[1,1],[1,0]] to the power n, scanning every exponent bit from the top.
    function longint unsigned fib_at(longint unsigned n, longint unsigned m);
      longint unsigned acc[4];
      longint unsigned bse[4];
      longint unsigned t[4];
      bse[0] = 1 % m; bse[1] = 1 % m; bse[2] = 1 % m; bse[3] = 0;
      acc[0] = 1 % m; acc[1] = 0; acc[2] = 0; acc[3] = 1 % m;
      for (int b = IW - 1; b >= 0; b--) begin
        t[0] = (acc[0] * acc[0] + acc[1] * acc[2]) % m;
        t[1] = (acc[0] * acc[1] + acc[1] * acc[3]) % m;
        t[2] = (acc[2] * acc[0] + acc[3] * acc[2]) % m;
        t[3] = (acc[2] * acc[1] + acc[3] * acc[3]) % m;
        acc = t;
        if (n[b]) begin
          t[0] = (acc[0] * bse[0] + acc[1] * bse[2]) % m;
          t[1] = (acc[0] * bse[1] + acc[1] * bse[3]) % m;
          t[2] = (acc[2] * bse[0] + acc[3] * bse[2]) % m;
          t[3] = (acc[2] * bse[1] + acc[3] * bse[3]) % m;
          acc = t;
        end
      end
      return acc[1];
    endfunction

    function void note_input(logic [IW-1:0] first, logic [IW-1:0] second);
      longint unsigned g;
      longint unsigned v;
      g = euclid_gcd(longint'(first), longint'(second));
      v = (modulus == 0) ? 0 : fib_at(g, longint'(modulus));
      pending_values.push_back(v[ModWidth-1:0]);
    endfunction

    function void check_result(logic [ModWidth-1:0] actual);
      logic [ModWidth-1:0] want;
      if (pending_values.size() == 0) begin
        $error("fib_value: no result expected, actual %0d", actual);
        fails++;
        return;
      end
      want = pending_values.pop_front();
      if (actual !== want) begin
        $error("fib_value: expected %0d, actual %0d", want, actual);
        fails++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [ModWidth-1:0] cfg_data_i = '0;
  longint unsigned cycle_count = 0;
  fib_gcd_scoreboard sb = new();

  fgm_in_if #(.IW(IW)) in_ch ();
  fgm_out_if out_ch ();

  fibonacci_of_gcd_mod_unit #(.INDEX_WIDTH(IW)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .in_i(in_ch.sink),
    .out_o(out_ch.source)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.first_index = '0;
    in_ch.second_index = '0;
    out_ch.ready = 1'b0;
  end

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fibonacci_of_gcd_mod_unit test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) sb.check_result(out_ch.fib_value);
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 120);
  endfunction

  // The receiver alternates between stretches without stalls and stretches of random stalls.
  initial begin
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(200, 3000)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 20)) begin
          out_ch.ready <= 1'b0;
          repeat (gap_len() + 1) @(posedge clk_i);
          out_ch.ready <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk_i);
        end
      end
    end
  end

  task automatic send_pair(logic [IW-1:0] first, logic [IW-1:0] second, int unsigned gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.first_index <= first;
    in_ch.second_index <= second;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_input(first, second);
  endtask

  task automatic write_modulus(logic [ModWidth-1:0] value);
    in_ch.valid <= 1'b0;
    while (sb.pending_values.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.modulus = value;
  endtask

  function automatic logic [IW-1:0] pick_index(logic [IW-1:0] common);
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    case ($urandom_range(0, 7))
      0: return '0;
      1: return IDX_MAX;
      2: return IW'($urandom_range(0, 200));
      3: return IW'(64'd1 << $urandom_range(0, IW - 1));
      4, 5: return common * IW'($urandom_range(1, 1 << 20));
      default: return w[IW-1:0];
    endcase
  endfunction

  task automatic run_phase(int unsigned count);
    logic [IW-1:0] common;
    logic [IW-1:0] a;
    logic [IW-1:0] b;
    // Corner pairs: both zero, one zero, ones, all-ones, powers of two and small values.
    send_pair('0, '0, gap_len());
    send_pair('0, IW'(5), gap_len());
    send_pair(IW'(5), '0, gap_len());
    send_pair(IW'(1), IW'(1), gap_len());
    send_pair(IDX_MAX, IDX_MAX, gap_len());
    send_pair(IDX_MAX, '0, gap_len());
    send_pair(IW'(1), IDX_MAX, gap_len());
    send_pair(IW'(64'd1 << 62), IW'(64'd1 << 61), gap_len());
    send_pair(IW'(12), IW'(18), gap_len());
    send_pair(IW'(2), IW'(3), gap_len());
    for (int i = 0; i < count; i++) begin
      common = IW'({$urandom(), $urandom()} >> $urandom_range(24, 63));
      a = pick_index(common);
      b = pick_index(common);
      send_pair(a, b, gap_len());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_phase(250);
    write_modulus(ModWidth'(2));
    run_phase(150);
    write_modulus({ModWidth{1'b1}});
    run_phase(250);
    write_modulus(ModWidth'($urandom_range(2, 1000)));
    run_phase(150);
    write_modulus(ModWidth'($urandom_range(2, 32'h7fff_ffff)));
    run_phase(150);
    in_ch.valid <= 1'b0;
    while (sb.pending_values.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.fails == 0) begin
      $display("fibonacci_of_gcd_mod_unit test passed");
    end else begin
      $display("fibonacci_of_gcd_mod_unit test failed");
    end
    $finish;
  end

endmodule
